/* design/spo2_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spo2_pkg: shared types and constants
// Controller states, datapath command/status structs, saturation table.
// ----------------------------------------------------------------------------
package spo2_pkg;

  localparam int SumW   = 44;
  localparam int LogW   = 25;   // signed Q8.16
  localparam int TblN   = 43;
  localparam int MantW  = 33;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_NORM,
    ST_LOG,
    ST_RDIV,
    ST_MAP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;      // clear sums, counters, estimate and busy flags
    logic acc;        // accumulate held item
    logic div_start;  // start mean divisions
    logic norm;       // normalize both means
    logic log_step;   // one squaring step
    logic rdiv_start; // start ratio division
    logic map;        // map ratio to estimate and clear sums
  } cmd_t;

  typedef struct packed {
    logic est_due;    // accumulate step reached the beat target
    logic div_done;
    logic log_done;
    logic rdiv_done;
  } stat_t;

  function automatic logic [6:0] sat_lookup(input logic [5:0] idx);
    logic [6:0] v;
    begin
      if (idx < 6'd4)       v = 7'd100;
      else if (idx < 6'd10) v = 7'd99;
      else if (idx < 6'd15) v = 7'd98;
      else if (idx < 6'd21) v = 7'd97;
      else if (idx < 6'd27) v = 7'd96;
      else if (idx < 6'd33) v = 7'd95;
      else if (idx < 6'd38) v = 7'd94;
      else                  v = 7'd93;
      return v;
    end
  endfunction

endpackage

/* design/spo2_ratio_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spo2_ratio_estimator: pulse oximeter saturation estimator
// Accumulates squared AC samples and maps the log ratio to percent SpO2.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | tdata {red_ac, ir_ac}, tuser {beat, command}
// out_    | out | tdata spo2, tuser new_estimate
// cfg_    | in  | data beats_per_estimate
//
// Sample item without estimate: accumulate step, then output step.
// Estimate item: the 44-step mean divider, 16 log squaring steps and the
// 32-step ratio divider. Clear item: clear, then output step. One item at a
// time; a held result makes the next item wait in its output step, further
// input waits behind it. Reset is synchronous, no clearing pass.
// ----------------------------------------------------------------------------
module spo2_ratio_estimator #(
  parameter int MAX_SAMPLES = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] ir_ac, [31:16] red_ac
  input  logic [1:0]  in_tuser,   // [0] command, [1] beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] spo2
  output logic        out_tuser,  // [0] new_estimate
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  logic [3:0] bpe_r;
  logic busy, emit, fresh, take;
  logic ov_r, fr_r;
  logic [6:0] sp_r, est;
  spo2_pkg::cmd_t cmd;
  spo2_pkg::stat_t stat;

  assign in_tready = !busy;
  assign take = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) bpe_r <= 4'd4;
    else if (cfg_valid) bpe_r <= cfg_data;
  end

  spo2_ctrl u_ctrl (
    .clk, .rst_n,
    .start(take && !in_tuser[0]),
    .start_clear(take && in_tuser[0]),
    .out_free(!ov_r || out_tready),
    .stat, .cmd, .busy, .emit, .fresh
  );

  spo2_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk, .rst_n,
    .load(take),
    .ir_in(in_tdata[15:0]),
    .red_in(in_tdata[31:16]),
    .beat_in(in_tuser[1]),
    .bpe(bpe_r),
    .cmd, .stat,
    .estimate(est)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (emit) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sp_r <= est;
      fr_r <= fresh;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {1'b0, sp_r};
  assign out_tuser = fr_r;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("input taken while busy");
  a_emit_ov: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_tvalid) else $error("result lost");
  a_spo2_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] <= 7'd100)) else $error("spo2 out of range");
`endif

endmodule

/* design/spo2_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spo2_ctrl: sequencer
// Sequences accumulate, mean divide, normalize, log, ratio divide and map.
// ----------------------------------------------------------------------------
module spo2_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              start_clear,
  input  logic              out_free,
  input  spo2_pkg::stat_t   stat,
  output spo2_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              emit,
  output logic              fresh
);

  spo2_pkg::state_t state_r, state_nxt;
  logic fresh_r, fresh_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spo2_pkg::ST_IDLE;
      fresh_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fresh_nxt = fresh_r;
    cmd = '0;
    emit = 1'b0;
    busy = (state_r != spo2_pkg::ST_IDLE);
    unique case (state_r)
      spo2_pkg::ST_IDLE: begin
        if (start_clear) begin
          cmd.clear = 1'b1;
          fresh_nxt = 1'b0;
          state_nxt = spo2_pkg::ST_OUT;
        end else if (start) begin
          state_nxt = spo2_pkg::ST_ACC;
        end
      end
      spo2_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (stat.est_due) begin
          cmd.div_start = 1'b1;
          state_nxt = spo2_pkg::ST_DIV;
        end else begin
          fresh_nxt = 1'b0;
          state_nxt = spo2_pkg::ST_OUT;
        end
      end
      spo2_pkg::ST_DIV: if (stat.div_done) state_nxt = spo2_pkg::ST_NORM;
      spo2_pkg::ST_NORM: begin
        cmd.norm = 1'b1;
        state_nxt = spo2_pkg::ST_LOG;
      end
      spo2_pkg::ST_LOG: begin
        // all 16 fraction bits are registered before the ratio divide starts
        if (stat.log_done) begin
          cmd.rdiv_start = 1'b1;
          state_nxt = spo2_pkg::ST_RDIV;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      spo2_pkg::ST_RDIV: if (stat.rdiv_done) state_nxt = spo2_pkg::ST_MAP;
      spo2_pkg::ST_MAP: begin
        cmd.map = 1'b1;
        fresh_nxt = 1'b1;
        state_nxt = spo2_pkg::ST_OUT;
      end
      spo2_pkg::ST_OUT: begin
        if (out_free) begin
          emit = 1'b1;
          state_nxt = spo2_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spo2_pkg::ST_IDLE;
    endcase
  end

  assign fresh = fresh_r;

endmodule

/* design/spo2_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spo2_dp: datapath
// Square sums, counters, shared-step mean divider, log2 squaring unit,
// ratio divider and table map.
// ----------------------------------------------------------------------------
module spo2_dp #(
  parameter int MAX_SAMPLES = 4095,
  parameter int CntW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic signed [15:0]   ir_in,
  input  logic signed [15:0]   red_in,
  input  logic                 beat_in,
  input  logic [3:0]           bpe,
  input  spo2_pkg::cmd_t       cmd,
  output spo2_pkg::stat_t      stat,
  output logic [6:0]           estimate
);

  localparam int SW = spo2_pkg::SumW;
  localparam int MW = spo2_pkg::MantW;
  localparam logic [SW-1:0] SumMax = {SW{1'b1}};
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SAMPLES);

  logic signed [15:0] ir_r, red_r;
  logic beat_r;
  logic [SW-1:0] ir_sum_r, red_sum_r;
  logic [CntW-1:0] cnt_r;
  logic [3:0] beats_r;
  logic [6:0] est_r;

  always_ff @(posedge clk) begin
    if (load) begin
      ir_r <= ir_in;
      red_r <= red_in;
      beat_r <= beat_in;
    end
  end

  // squares: 16x16 each
  logic [31:0] ir_sq, red_sq;
  logic [SW:0] ir_add, red_add;
  logic [3:0] beats_inc;
  assign ir_sq  = 32'($signed(ir_r) * $signed(ir_r));
  assign red_sq = 32'($signed(red_r) * $signed(red_r));
  assign ir_add  = {1'b0, ir_sum_r} + {13'd0, ir_sq};
  assign red_add = {1'b0, red_sum_r} + {13'd0, red_sq};
  assign beats_inc = beats_r + 4'd1;
  assign stat.est_due = beat_r && (beats_inc == bpe);

  // mean division: restoring, both channels share the counter
  logic [SW-1:0] iq_r, rq_r;     // quotient / dividend shift
  logic [CntW:0] irem_r, rrem_r;
  logic [5:0] dstep_r;
  logic dbusy_r;
  logic [CntW-1:0] den;
  logic [CntW:0] itr, rtr;
  assign den = (cnt_r == '0) ? CntW'(1) : cnt_r;
  assign itr = {irem_r[CntW-1:0], iq_r[SW-1]};
  assign rtr = {rrem_r[CntW-1:0], rq_r[SW-1]};

  // log unit
  logic [MW-1:0] lx_r [2];
  logic [15:0] lf_r [2];
  logic [5:0] lk_r [2];
  logic [4:0] lstep_r;
  logic zero_r;

  // ratio division (magnitudes)
  logic signed [spo2_pkg::LogW-1:0] li, lr;
  logic [31:0] rn_r;            // |lr*100| shifting
  logic [24:0] rd_r;
  logic [25:0] rrm_r;
  logic [5:0] rstep_r;
  logic rbusy_r, rneg_r;
  logic [25:0] rtr2;
  assign rtr2 = {rrm_r[24:0], rn_r[31]};

  always_comb begin
    li = $signed({1'b0, lk_r[0], lf_r[0]}) - $signed(25'(8 << 16));
    lr = $signed({1'b0, lk_r[1], lf_r[1]}) - $signed(25'(8 << 16));
  end

  // leading one position of a mean
  function automatic logic [5:0] lead1(input logic [SW-1:0] m);
    logic [5:0] k;
    begin
      k = '0;
      for (int i = 0; i < SW; i++) if (m[i]) k = 6'(i);
      return k;
    end
  endfunction

  function automatic logic [MW-1:0] mant(input logic [SW-1:0] m, input logic [5:0] k);
    logic [SW+31:0] w;
    begin
      w = {32'd0, m} << (6'd31 - (k > 6'd31 ? 6'd31 : k));
      if (k > 6'd31) w = {32'd0, m >> (k - 6'd31)};
      return MW'(w[31:0]);
    end
  endfunction

  // squaring step: one 32x32 per lane
  logic [63:0] sq [2];
  logic [MW-1:0] nx [2];
  logic nb [2];
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      sq[j] = lx_r[j][31:0] * lx_r[j][31:0];
      nb[j] = sq[j][63];
      nx[j] = nb[j] ? MW'(sq[j][63:32]) : MW'(sq[j][62:31]);
    end
  end

  // ratio to index
  logic [31:0] ratio_mag;
  logic [5:0] idx;
  always_comb begin
    ratio_mag = rn_r;
    idx = '0;
    if (!rneg_r && !zero_r) begin
      if (ratio_mag > 32'd108)     idx = 6'd42;
      else if (ratio_mag > 32'd66) idx = 6'(ratio_mag - 32'd66);
      else if (ratio_mag > 32'd50) idx = 6'(ratio_mag - 32'd50);
    end
  end

  logic [31:0] prod;
  assign prod = 32'($unsigned(lr[24] ? -lr : lr)) * 32'd100;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      ir_sum_r <= '0;
      red_sum_r <= '0;
      cnt_r <= '0;
      beats_r <= '0;
      est_r <= '0;
      dbusy_r <= 1'b0;
      rbusy_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        ir_sum_r <= ir_add[SW] ? SumMax : ir_add[SW-1:0];
        red_sum_r <= red_add[SW] ? SumMax : red_add[SW-1:0];
        if (cnt_r != CntMax) cnt_r <= cnt_r + 1'b1;
        if (beat_r) beats_r <= beats_inc;
      end
      if (cmd.div_start) begin
        iq_r <= ir_add[SW] ? SumMax : ir_add[SW-1:0];
        rq_r <= red_add[SW] ? SumMax : red_add[SW-1:0];
        irem_r <= '0;
        rrem_r <= '0;
        dstep_r <= '0;
        dbusy_r <= 1'b1;
      end else if (dbusy_r) begin
        if (itr >= {1'b0, den}) begin
          irem_r <= itr - {1'b0, den};
          iq_r <= {iq_r[SW-2:0], 1'b1};
        end else begin
          irem_r <= itr;
          iq_r <= {iq_r[SW-2:0], 1'b0};
        end
        if (rtr >= {1'b0, den}) begin
          rrem_r <= rtr - {1'b0, den};
          rq_r <= {rq_r[SW-2:0], 1'b1};
        end else begin
          rrem_r <= rtr;
          rq_r <= {rq_r[SW-2:0], 1'b0};
        end
        dstep_r <= dstep_r + 6'd1;
        if (dstep_r == 6'(SW - 1)) dbusy_r <= 1'b0;
      end
      if (cmd.norm) begin
        zero_r <= (iq_r == '0) || (rq_r == '0);
        lk_r[0] <= lead1(iq_r);
        lk_r[1] <= lead1(rq_r);
        lx_r[0] <= mant(iq_r, lead1(iq_r));
        lx_r[1] <= mant(rq_r, lead1(rq_r));
        lf_r[0] <= '0;
        lf_r[1] <= '0;
        lstep_r <= '0;
      end
      if (cmd.log_step) begin
        for (int j = 0; j < 2; j++) begin
          lx_r[j] <= nx[j];
          lf_r[j] <= {lf_r[j][14:0], nb[j]};
        end
        lstep_r <= lstep_r + 5'd1;
      end
      if (cmd.rdiv_start) begin
        if (li == '0) zero_r <= 1'b1;
        rneg_r <= (lr[24] != li[24]) && (lr != '0);
        rn_r <= prod;
        rd_r <= 25'($unsigned(li[24] ? -li : li));
        rrm_r <= '0;
        rstep_r <= '0;
        rbusy_r <= 1'b1;
      end else if (rbusy_r) begin
        if (rtr2 >= {1'b0, rd_r}) begin
          rrm_r <= rtr2 - {1'b0, rd_r};
          rn_r <= {rn_r[30:0], 1'b1};
        end else begin
          rrm_r <= rtr2;
          rn_r <= {rn_r[30:0], 1'b0};
        end
        rstep_r <= rstep_r + 6'd1;
        if (rstep_r == 6'd31) rbusy_r <= 1'b0;
      end
      if (cmd.map) begin
        est_r <= spo2_pkg::sat_lookup(idx);
        ir_sum_r <= '0;
        red_sum_r <= '0;
        cnt_r <= '0;
        beats_r <= '0;
      end
    end
  end

  assign stat.div_done  = !dbusy_r;
  assign stat.log_done  = (lstep_r == 5'd16);
  assign stat.rdiv_done = !rbusy_r;
  assign estimate = est_r;

endmodule
